/* rtl/core/tag_occurrence_table_with_verdict_assert.svh */
// Assertion macros shared by the checker of the tag occurrence table.
// Depends on nothing; the including file supplies clock, reset and signals.
`ifndef TAG_OCCURRENCE_TABLE_WITH_VERDICT_ASSERT_SVH
`define TAG_OCCURRENCE_TABLE_WITH_VERDICT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TOCV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TOCV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tocv_pkg.sv */
// Shared types and constants of the tag occurrence table with verdict.
// Used by the top level and the checker; depends on nothing.
package tocv_pkg;

  localparam int EXEC_W    = 8;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_EXEC_PER_RUN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXCL_PCT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHARED_PCT   = 2'd2;

  localparam logic [EXEC_W-1:0] EXEC_RESET   = 8'd11;
  localparam logic [PCT_W-1:0]  EXCL_RESET   = 7'd75;
  localparam logic [PCT_W-1:0]  SHARED_RESET = 7'd80;

  // The exclusive limit is E*X/100. The product fits in 15 bits, and for such values
  // multiplying by 5243 and dropping 19 bits gives the exact quotient.
  localparam int PROD_W        = EXEC_W + PCT_W;
  localparam int LIMIT_RECIP_W = 13;
  localparam logic [LIMIT_RECIP_W-1:0] LIMIT_RECIP = 13'd5243;
  localparam int LIMIT_SHIFT   = 19;
  localparam int LIMIT_W       = 9;

  localparam logic [1:0] RUN_ONE = 2'd1;
  localparam logic [1:0] RUN_TWO = 2'd2;

  typedef enum logic [1:0] {
    OP_RECORD   = 2'd0,
    OP_EVALUATE = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_COUNTED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_VERDICT  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    VD_INCONCLUSIVE = 2'd0,
    VD_COUNTER      = 2'd1,
    VD_VALID        = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_SCAN = 3'd1,
    S_MUL  = 3'd2,
    S_VERD = 3'd3,
    S_EMIT = 3'd4
  } state_t;

endpackage

/* rtl/core/tocv_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; no package dependency.
module tocv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/tag_occurrence_table_with_verdict.sv */
// Top level of the tag occurrence table with verdict.
// Depends on tocv_pkg and tocv_ram.
//
// Usage: items arrive on the in_valid/in_ready channel (operation, line_tag,
// line_valid, run_id) and each one yields exactly one result on the
// out_valid/out_ready channel (status, verdict, entries_used). Registers are
// written on the cfg_valid/cfg_ready channel, which is always ready; input
// is held off while a register write is offered and until a settle counter
// has run down, while the exclusive limit is recomputed.
// Occupied entries always sit at the low addresses of one RAM, so a lookup
// reads them one per cycle. A record item scans until a hit or the last
// occupied entry, an evaluate item scans every occupied entry and then
// passes through S_MUL and S_VERD, and a clear or ignored item goes
// straight to S_EMIT. The result is held in an output register, so the
// next item is taken while the receiver stalls; only a second finished
// result waits for the first to be taken.
// Reset empties the table at once (the fill count is cleared) and restores
// the register defaults 11, 75 and 80.
module tag_occurrence_table_with_verdict #(
  parameter int TABLE_ENTRIES = 32,
  parameter int TAG_WIDTH     = 40,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             operation,
  input  logic [TAG_WIDTH-1:0]                   line_tag,
  input  logic                                   line_valid,
  input  logic [1:0]                             run_id,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0]                             status,
  output logic [1:0]                             verdict,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0]     entries_used,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tocv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tocv_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W    = TAG_WIDTH + COUNT_WIDTH + 2;
  localparam int SUM_W     = COUNT_WIDTH + CNT_W;
  localparam int TOT_W     = tocv_pkg::EXEC_W + 1 + CNT_W;
  localparam int LHS_W     = SUM_W + tocv_pkg::PCT_W;
  localparam int RHS_W     = TOT_W + tocv_pkg::PCT_W;
  localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int LIM_CMP_W = (COUNT_WIDTH > tocv_pkg::LIMIT_W) ? COUNT_WIDTH
                                                                : tocv_pkg::LIMIT_W;
  localparam int SCALED_W  = tocv_pkg::PROD_W + tocv_pkg::LIMIT_RECIP_W;

  tocv_pkg::state_t   state, state_next;
  tocv_pkg::op_t      op_q;
  tocv_pkg::status_t  res_status;
  tocv_pkg::verdict_t res_verdict;

  logic [TAG_WIDTH-1:0] tag_q;
  logic [1:0]           run_q;
  logic [CNT_W-1:0]     used;
  logic [CNT_W-1:0]     rd_cnt;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;

  logic [tocv_pkg::EXEC_W-1:0] exec_per_run;
  logic [tocv_pkg::PCT_W-1:0]  excl_pct;
  logic [tocv_pkg::PCT_W-1:0]  shared_pct;
  logic [1:0]                  settle;

  logic [tocv_pkg::PROD_W-1:0]  prod_q;
  logic [SCALED_W-1:0]          scaled;
  logic [tocv_pkg::LIMIT_W-1:0] limit_q;

  logic             any_counter;
  logic             any_weak;
  logic [SUM_W-1:0] shared_sum;
  logic [TOT_W-1:0] total_sum;
  logic [LHS_W-1:0] lhs_q;
  logic [RHS_W-1:0] rhs_q;

  logic in_fire, cfg_fire, out_free;
  logic rd_issue, hit, scan_end, wr_en, has_room;
  logic run_one, run_two;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;

  logic [TAG_WIDTH-1:0]   rd_tag;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   rd_one, rd_two;

  tocv_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_issue),
    .rd_addr(rd_cnt[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  // Entry word layout: tag, count, run-two flag, run-one flag.
  assign rd_tag   = rd_data[WORD_W-1 -: TAG_WIDTH];
  assign rd_count = rd_data[2 +: COUNT_WIDTH];
  assign rd_two   = rd_data[1];
  assign rd_one   = rd_data[0];

  assign run_one   = (run_q == tocv_pkg::RUN_ONE);
  assign run_two   = (run_q == tocv_pkg::RUN_TWO);
  assign count_inc = (&rd_count) ? rd_count : rd_count + COUNT_WIDTH'(1);
  assign has_room  = (used < CNT_W'(TABLE_ENTRIES));
  assign scaled    = SCALED_W'(prod_q) * SCALED_W'(tocv_pkg::LIMIT_RECIP);

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_fire   = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      tocv_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((tocv_pkg::op_t'(operation) == tocv_pkg::OP_RECORD && line_valid) ||
              tocv_pkg::op_t'(operation) == tocv_pkg::OP_EVALUATE) begin
            state_next = tocv_pkg::S_SCAN;
          end else begin
            state_next = tocv_pkg::S_EMIT;
          end
        end
      end
      tocv_pkg::S_SCAN: begin
        if (op_q == tocv_pkg::OP_RECORD) begin
          if (hit || scan_end) begin
            state_next = tocv_pkg::S_EMIT;
          end
        end else if (scan_end) begin
          state_next = tocv_pkg::S_MUL;
        end
      end
      tocv_pkg::S_MUL:  state_next = tocv_pkg::S_VERD;
      tocv_pkg::S_VERD: state_next = tocv_pkg::S_EMIT;
      tocv_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = tocv_pkg::S_IDLE;
        end
      end
      default: state_next = tocv_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    in_ready = 1'b0;
    hit      = 1'b0;
    scan_end = 1'b0;
    rd_issue = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = used[IDX_W-1:0];
    wr_data  = {tag_q, COUNT_WIDTH'(1), run_two, run_one};
    unique case (state)
      tocv_pkg::S_IDLE: begin
        // Hold input off while a register write is taking effect.
        in_ready = (settle == 2'd0) && !cfg_valid;
      end
      tocv_pkg::S_SCAN: begin
        hit      = rd_vld && (op_q == tocv_pkg::OP_RECORD) && (rd_tag == tag_q);
        scan_end = !rd_vld && (rd_cnt >= used);
        rd_issue = (rd_cnt < used) && !hit;
        if (op_q == tocv_pkg::OP_RECORD) begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx;
            wr_data = {rd_tag, count_inc, rd_two | run_two, rd_one | run_one};
          end else if (scan_end && has_room) begin
            wr_en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tocv_pkg::S_IDLE;
      used         <= '0;
      rd_cnt       <= '0;
      rd_vld       <= 1'b0;
      out_valid    <= 1'b0;
      settle       <= 2'd0;
      exec_per_run <= tocv_pkg::EXEC_RESET;
      excl_pct     <= tocv_pkg::EXCL_RESET;
      shared_pct   <= tocv_pkg::SHARED_RESET;
    end else begin
      state  <= state_next;
      rd_vld <= rd_issue;

      if (cfg_fire) begin
        settle <= 2'd2;
        unique case (cfg_index)
          tocv_pkg::REG_EXEC_PER_RUN: exec_per_run <= cfg_data;
          tocv_pkg::REG_EXCL_PCT:     excl_pct <= cfg_data[tocv_pkg::PCT_W-1:0];
          tocv_pkg::REG_SHARED_PCT:   shared_pct <= cfg_data[tocv_pkg::PCT_W-1:0];
          default: begin
          end
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end

      if (in_fire) begin
        rd_cnt <= '0;
        if (tocv_pkg::op_t'(operation) == tocv_pkg::OP_CLEAR) begin
          used <= '0;
        end
      end else if (rd_issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end

      if (wr_en && !hit) begin
        used <= used + CNT_W'(1);
      end

      if (state == tocv_pkg::S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    rd_idx  <= rd_cnt[IDX_W-1:0];
    prod_q  <= tocv_pkg::PROD_W'(exec_per_run) * tocv_pkg::PROD_W'(excl_pct);
    limit_q <= scaled[tocv_pkg::LIMIT_SHIFT +: tocv_pkg::LIMIT_W];

    if (in_fire) begin
      op_q        <= tocv_pkg::op_t'(operation);
      tag_q       <= line_tag;
      run_q       <= run_id;
      any_counter <= 1'b0;
      any_weak    <= 1'b0;
      shared_sum  <= '0;
      total_sum   <= '0;
      res_verdict <= tocv_pkg::VD_INCONCLUSIVE;
      if (tocv_pkg::op_t'(operation) == tocv_pkg::OP_CLEAR) begin
        res_status <= tocv_pkg::ST_CLEARED;
      end else begin
        res_status <= tocv_pkg::ST_IGNORED;
      end
    end

    if (state == tocv_pkg::S_SCAN) begin
      if (op_q == tocv_pkg::OP_RECORD) begin
        if (hit) begin
          res_status <= tocv_pkg::ST_COUNTED;
        end else if (scan_end) begin
          res_status <= has_room ? tocv_pkg::ST_INSERTED : tocv_pkg::ST_DROPPED;
        end
      end else if (rd_vld) begin
        // An entry seen in exactly one run is exclusive.
        if (rd_one ^ rd_two) begin
          if (LIM_CMP_W'(rd_count) > LIM_CMP_W'(limit_q)) begin
            any_counter <= 1'b1;
          end else begin
            any_weak <= 1'b1;
          end
        end else begin
          total_sum <= total_sum + TOT_W'({exec_per_run, 1'b0});
          if (rd_one && rd_two) begin
            shared_sum <= shared_sum + SUM_W'(rd_count);
          end
        end
      end
    end

    if (state == tocv_pkg::S_MUL) begin
      // The share test shared*100/total >= S is done as shared*100 >= S*total.
      lhs_q <= (LHS_W'(shared_sum) << 6) + (LHS_W'(shared_sum) << 5) +
               (LHS_W'(shared_sum) << 2);
      rhs_q <= RHS_W'(shared_pct) * RHS_W'(total_sum);
    end

    if (state == tocv_pkg::S_VERD) begin
      res_status <= tocv_pkg::ST_VERDICT;
      if (any_counter) begin
        res_verdict <= tocv_pkg::VD_COUNTER;
      end else if (used == '0 || any_weak || total_sum == '0) begin
        res_verdict <= tocv_pkg::VD_INCONCLUSIVE;
      end else if (CMP_W'(lhs_q) >= CMP_W'(rhs_q)) begin
        res_verdict <= tocv_pkg::VD_VALID;
      end else begin
        res_verdict <= tocv_pkg::VD_INCONCLUSIVE;
      end
    end

    if (state == tocv_pkg::S_EMIT && out_free) begin
      status       <= res_status;
      verdict      <= res_verdict;
      entries_used <= used;
    end
  end

endmodule

/* rtl/core/tocv_checker.sv */
// Port-level checker for the tag occurrence table, bound to the top level.
// Depends on tocv_pkg and the assertion macro header.
`include "tag_occurrence_table_with_verdict_assert.svh"

module tocv_checker #(
  parameter int TABLE_ENTRIES = 32
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [2:0]                         status,
  input logic [1:0]                         verdict,
  input logic [$clog2(TABLE_ENTRIES+1)-1:0] entries_used
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  `TOCV_ASSERT_NOW(a_used_bound, clk, rst, out_valid, entries_used <= CNT_W'(TABLE_ENTRIES), "occupancy above table size")
  `TOCV_ASSERT_NOW(a_clear_empties, clk, rst, out_valid && status == tocv_pkg::ST_CLEARED, entries_used == '0, "clear left entries occupied")
  `TOCV_ASSERT_NOW(a_verdict_only_eval, clk, rst, out_valid && status != tocv_pkg::ST_VERDICT, verdict == tocv_pkg::VD_INCONCLUSIVE, "verdict on a non-evaluate result")
  `TOCV_ASSERT_NOW(a_insert_occupies, clk, rst, out_valid && (status == tocv_pkg::ST_INSERTED || status == tocv_pkg::ST_COUNTED), entries_used != '0, "recorded tag but table empty")
  `TOCV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(verdict) && $stable(entries_used), "stalled result changed")

endmodule

bind tag_occurrence_table_with_verdict tocv_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .verdict     (verdict),
  .entries_used(entries_used)
);
